[rtl/iol_pkg.sv]
`timescale 1ns / 1ps
package iol_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_ISSUE    = 2'd1,
      FUNC_COMPLETE = 2'd2,
      FUNC_UNUSED   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_COUNTED  = 2'd0,
      STATUS_NO_START = 2'd1,
      STATUS_NEGATIVE = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_FILTER_CGROUP = 3'd0,
      CSR_PER_DISK      = 3'd1,
      CSR_PER_FLAGS     = 3'd2,
      CSR_QUEUED_MODE   = 3'd3,
      CSR_UNIT_MILLIS   = 3'd4,
      CSR_FILTER_DEVICE = 3'd5,
      CSR_TARGET_DEVICE = 3'd6,
      CSR_NONE          = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SCALE,
      ST_COUNT,
      ST_FAIL
   } state_type;

   typedef struct packed {
      logic found;
      logic full;
   } key_match_type;

   localparam int unsigned DIV_US          = 1000;
   localparam int unsigned DIV_MS          = 1000000;
   localparam int unsigned DEV_MAJOR_SHIFT = 20;

endpackage

[rtl/iol_ram.sv]
`timescale 1ns / 1ps
module iol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/iol_key_table.sv]
`timescale 1ns / 1ps
module iol_key_table #(
   parameter int KEYS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [63:0]                           key,
   input  logic                                  alloc_en,
   output iol_pkg::key_match_type                match,
   output logic [(KEYS > 1 ? $clog2(KEYS) : 1)-1:0] index
);
   localparam int KEY_W = KEYS > 1 ? $clog2(KEYS) : 1;

   logic [KEYS-1:0] key_valid_ff;
   logic [KEYS-1:0] key_valid_in;
   logic [63:0]     key_value_ff [KEYS];
   logic            found;
   logic            have_free;
   logic [KEY_W-1:0] found_idx;
   logic [KEY_W-1:0] free_idx;

   always_comb begin
      found     = 1'b0;
      have_free = 1'b0;
      found_idx = '0;
      free_idx  = '0;
      for (int k = KEYS - 1; k >= 0; k--) begin
         if (key_valid_ff[k] && key_value_ff[k] == key) begin
            found     = 1'b1;
            found_idx = KEY_W'(k);
         end
         if (!key_valid_ff[k]) begin
            have_free = 1'b1;
            free_idx  = KEY_W'(k);
         end
      end
   end

   assign match.found = found;
   assign match.full  = !found && !have_free;
   assign index       = found ? found_idx : free_idx;

   always_comb begin
      key_valid_in = key_valid_ff;
      if (alloc_en) begin
         key_valid_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
      end else begin
         key_valid_ff <= key_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc_en) begin
         key_value_ff[free_idx] <= key;
      end
   end
endmodule

[rtl/iol_slot.sv]
`timescale 1ns / 1ps
module iol_slot #(
   parameter int SLOTS = 27
) (
   input  logic [62:0]                 delta,
   input  logic                        unit_millis,
   output logic [$clog2(SLOTS)-1:0]    slot
);
   localparam int SLOT_W = $clog2(SLOTS);

   logic [127:0] wide;

   assign wide = 128'(delta);

   always_comb begin
      slot = '0;
      for (int s = 1; s < SLOTS; s++) begin
         if (unit_millis ? (wide >= (128'(iol_pkg::DIV_MS) << s))
                         : (wide >= (128'(iol_pkg::DIV_US) << s))) begin
            slot = SLOT_W'(s);
         end
      end
   end
endmodule

[rtl/io_latency_histogram_core.sv]
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | func, tag, timestamp, cgroup, elevator, disk, flags
// rsp     | out       | rsp_valid/rsp_ready | status, key_index, bucket, bucket_count
// csr     | in        | csr_we              | csr_index, csr_wdata
// Insert, issue, filtered and unknown beats stay in ST_IDLE; a complete beat (start read,
// key search, counter RMW) goes to ST_LOOK, then to ST_FAIL with an early status or via
// ST_SCALE to ST_COUNT. After reset ST_CLEAR zeroes all counter cells; req_ready is low.
// A pending rsp beat does not block req; a complete beat holds in its last state
// until the rsp register is free.
module io_latency_histogram_core #(
   parameter int TAGS  = 256,
   parameter int KEYS  = 16,
   parameter int SLOTS = 27
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_request_tag,
   input  logic [63:0] req_timestamp_ns,
   input  logic        req_in_cgroup,
   input  logic        req_has_elevator,
   input  logic        req_disk_present,
   input  logic [11:0] req_disk_major,
   input  logic [19:0] req_disk_first_minor,
   input  logic [31:0] req_command_flags,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_key_index,
   output logic [4:0]  rsp_bucket,
   output logic [31:0] rsp_bucket_count,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int TAG_W   = $clog2(TAGS);
   localparam int KEY_W   = KEYS > 1 ? $clog2(KEYS) : 1;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CELLS   = KEYS * SLOTS;
   localparam int ADDR_W  = CELLS > 1 ? $clog2(CELLS) : 1;

   iol_pkg::state_type state_ff, state_in;

   logic        filter_cgroup_ff, per_disk_ff, per_flags_ff;
   logic        queued_mode_ff, unit_millis_ff, filter_device_ff;
   logic [31:0] target_device_ff;

   logic [TAGS-1:0]   start_valid_ff, start_valid_in;
   logic [TAG_W-1:0]  tag_idx_ff;
   logic              hit_ff;
   logic [63:0]       ts_ff;
   logic [63:0]       key_ff;
   logic [62:0]       delta_ff;
   logic [KEY_W-1:0]  key_idx_ff;
   logic [SLOT_W-1:0] slot_ff;
   iol_pkg::status_type status_ff, status_in;
   logic [ADDR_W-1:0] clr_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [3:0]        rsp_key_index_ff;
   logic [4:0]        rsp_bucket_ff;
   logic [31:0]       rsp_bucket_count_ff;

   logic [31:0]       tag32;
   logic [TAG_W-1:0]  tag_idx;
   logic              tag_ok;
   logic [31:0]       device;
   logic              accept;
   logic              pass;
   logic              store;
   logic              complete;
   logic [63:0]       start_rdata;
   logic [63:0]       delta;
   iol_pkg::key_match_type key_match;
   logic [KEY_W-1:0]  key_index;
   logic              alloc_en;
   logic [SLOT_W-1:0] slot;
   logic [ADDR_W-1:0] cell_addr;
   logic [31:0]       cnt_rdata;
   logic              cnt_we;
   logic [ADDR_W-1:0] cnt_waddr;
   logic [31:0]       cnt_wdata;
   logic              cnt_re;
   logic              out_free;
   logic              emit;

   assign tag32   = 32'(req_request_tag);
   assign tag_idx = tag32[TAG_W-1:0];
   assign tag_ok  = tag32 < 32'(TAGS);
   assign device  = req_disk_present
                  ? ((32'(req_disk_major) << iol_pkg::DEV_MAJOR_SHIFT)
                     | 32'(req_disk_first_minor))
                  : 32'd0;

   assign accept   = req_valid && req_ready;
   assign pass     = !(filter_cgroup_ff && !req_in_cgroup);
   assign store    = pass && tag_ok
                  && (req_func == iol_pkg::FUNC_INSERT
                      || (req_func == iol_pkg::FUNC_ISSUE
                          && !(queued_mode_ff && req_has_elevator)))
                  && !(filter_device_ff && target_device_ff != device);
   assign complete = pass && req_func == iol_pkg::FUNC_COMPLETE;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign delta    = ts_ff - start_rdata;

   function automatic logic [ADDR_W-1:0] cell_addr_hold();
      return ADDR_W'(key_idx_ff) * ADDR_W'(SLOTS) + ADDR_W'(slot_ff);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_cgroup_ff <= 1'b0;
         per_disk_ff      <= 1'b0;
         per_flags_ff     <= 1'b0;
         queued_mode_ff   <= 1'b0;
         unit_millis_ff   <= 1'b0;
         filter_device_ff <= 1'b0;
         target_device_ff <= '0;
      end else if (csr_we) begin
         unique case (iol_pkg::csr_index_type'(csr_index))
            iol_pkg::CSR_FILTER_CGROUP: filter_cgroup_ff <= csr_wdata[0];
            iol_pkg::CSR_PER_DISK:      per_disk_ff      <= csr_wdata[0];
            iol_pkg::CSR_PER_FLAGS:     per_flags_ff     <= csr_wdata[0];
            iol_pkg::CSR_QUEUED_MODE:   queued_mode_ff   <= csr_wdata[0];
            iol_pkg::CSR_UNIT_MILLIS:   unit_millis_ff   <= csr_wdata[0];
            iol_pkg::CSR_FILTER_DEVICE: filter_device_ff <= csr_wdata[0];
            iol_pkg::CSR_TARGET_DEVICE: target_device_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   iol_ram #(.WIDTH(64), .DEPTH(TAGS)) u_start_ram (
      .clock (clock),
      .we    (accept && store),
      .waddr (tag_idx),
      .wdata (req_timestamp_ns),
      .re    (accept && complete),
      .raddr (tag_idx),
      .rdata (start_rdata)
   );

   iol_key_table #(.KEYS(KEYS)) u_key_table (
      .clock    (clock),
      .reset    (reset),
      .key      (key_ff),
      .alloc_en (alloc_en),
      .match    (key_match),
      .index    (key_index)
   );

   iol_slot #(.SLOTS(SLOTS)) u_slot (
      .delta       (delta_ff),
      .unit_millis (unit_millis_ff),
      .slot        (slot)
   );

   assign cell_addr = ADDR_W'(key_idx_ff) * ADDR_W'(SLOTS) + ADDR_W'(slot);

   iol_ram #(.WIDTH(32), .DEPTH(CELLS)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cnt_re),
      .raddr (cell_addr),
      .rdata (cnt_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iol_pkg::ST_CLEAR: begin
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = iol_pkg::ST_IDLE;
            end
         end
         iol_pkg::ST_IDLE: begin
            if (accept && complete) begin
               state_in = iol_pkg::ST_LOOK;
            end
         end
         iol_pkg::ST_LOOK: begin
            if (!hit_ff || delta[63] || key_match.full) begin
               state_in = iol_pkg::ST_FAIL;
            end else begin
               state_in = iol_pkg::ST_SCALE;
            end
         end
         iol_pkg::ST_SCALE: state_in = iol_pkg::ST_COUNT;
         iol_pkg::ST_COUNT, iol_pkg::ST_FAIL: begin
            if (out_free) begin
               state_in = iol_pkg::ST_IDLE;
            end
         end
         default: state_in = iol_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      alloc_en       = 1'b0;
      cnt_re         = 1'b0;
      cnt_we         = 1'b0;
      cnt_waddr      = cell_addr;
      cnt_wdata      = cnt_rdata + 32'd1;
      emit           = 1'b0;
      status_in      = status_ff;
      start_valid_in = start_valid_ff;
      unique case (state_ff)
         iol_pkg::ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
         end
         iol_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && store) begin
               start_valid_in[tag_idx] = 1'b1;
            end
         end
         iol_pkg::ST_LOOK: begin
            if (!hit_ff) begin
               status_in = iol_pkg::STATUS_NO_START;
            end else begin
               start_valid_in[tag_idx_ff] = 1'b0;
               if (delta[63]) begin
                  status_in = iol_pkg::STATUS_NEGATIVE;
               end else if (key_match.full) begin
                  status_in = iol_pkg::STATUS_FULL;
               end else begin
                  status_in = iol_pkg::STATUS_COUNTED;
                  alloc_en  = !key_match.found;
               end
            end
         end
         iol_pkg::ST_SCALE: cnt_re = 1'b1;
         iol_pkg::ST_COUNT: begin
            emit   = out_free;
            cnt_we = out_free;
            cnt_waddr = cell_addr_hold();
         end
         iol_pkg::ST_FAIL: emit = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= iol_pkg::ST_CLEAR;
         clr_ff         <= '0;
         start_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_valid_ff <= start_valid_in;
         rsp_valid_ff   <= emit || (rsp_valid_ff && !rsp_ready);
         if (state_ff == iol_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (accept) begin
         tag_idx_ff <= tag_idx;
         hit_ff     <= tag_ok && start_valid_ff[tag_idx];
         ts_ff      <= req_timestamp_ns;
         key_ff     <= {per_disk_ff ? device : 32'd0,
                        per_flags_ff ? req_command_flags : 32'd0};
      end
      if (state_ff == iol_pkg::ST_LOOK) begin
         delta_ff   <= delta[62:0];
         key_idx_ff <= key_index;
      end
      if (state_ff == iol_pkg::ST_SCALE) begin
         slot_ff <= slot;
      end
      if (emit) begin
         rsp_status_ff <= status_ff;
         if (state_ff == iol_pkg::ST_COUNT) begin
            rsp_key_index_ff    <= 4'(key_idx_ff);
            rsp_bucket_ff       <= 5'(slot_ff);
            rsp_bucket_count_ff <= cnt_wdata;
         end else begin
            rsp_key_index_ff    <= '0;
            rsp_bucket_ff       <= '0;
            rsp_bucket_count_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_key_index    = rsp_key_index_ff;
   assign rsp_bucket       = rsp_bucket_ff;
   assign rsp_bucket_count = rsp_bucket_count_ff;
endmodule

[dv/io_latency_histogram_checker.sv]
`timescale 1ns / 1ps
module io_latency_histogram_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_request_tag,
   input  logic [63:0] req_timestamp_ns,
   input  logic        req_in_cgroup,
   input  logic        req_has_elevator,
   input  logic        req_disk_present,
   input  logic [11:0] req_disk_major,
   input  logic [19:0] req_disk_first_minor,
   input  logic [31:0] req_command_flags,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [3:0]  rsp_key_index,
   input  logic [4:0]  rsp_bucket,
   input  logic [31:0] rsp_bucket_count,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int TAGS = 256;
   localparam int KEYS = 16;
   localparam int SLOTS = 27;

   typedef struct packed {
      iol_pkg::status_type status;
      logic [3:0]  key_index;
      logic [4:0]  bucket;
      logic [31:0] bucket_count;
   } outcome_type;

   logic        cg_filter, disk_split, flag_split, queued, millis, dev_filter;
   logic [31:0] target;
   logic        tag_live [TAGS];
   logic [63:0] tag_start [TAGS];
   logic        key_live [KEYS];
   logic [63:0] key_word [KEYS];
   logic [31:0] hist [KEYS*SLOTS];
   outcome_type outcomes [$];

   assign pending_count = outcomes.size();

   function automatic logic [31:0] device_number();
      return req_disk_present ? {req_disk_major, req_disk_first_minor} : 32'd0;
   endfunction

   task automatic predict_latency();
      outcome_type o;
      logic [63:0] delta, key;
      int found, free_k, slot;
      o = '0;
      if (cg_filter && !req_in_cgroup)
         return;
      if (req_func == iol_pkg::FUNC_INSERT || req_func == iol_pkg::FUNC_ISSUE) begin
         if (req_func == iol_pkg::FUNC_ISSUE && queued && req_has_elevator)
            return;
         if (dev_filter && target != device_number())
            return;
         tag_live[req_request_tag] = 1'b1;
         tag_start[req_request_tag] = req_timestamp_ns;
         return;
      end
      if (req_func != iol_pkg::FUNC_COMPLETE)
         return;
      if (!tag_live[req_request_tag]) begin
         o.status = iol_pkg::STATUS_NO_START;
         outcomes.push_back(o);
         return;
      end
      delta = req_timestamp_ns - tag_start[req_request_tag];
      tag_live[req_request_tag] = 1'b0;
      if (delta[63]) begin
         o.status = iol_pkg::STATUS_NEGATIVE;
         outcomes.push_back(o);
         return;
      end
      key = {disk_split ? device_number() : 32'd0, flag_split ? req_command_flags : 32'd0};
      found = -1;
      free_k = -1;
      for (int k = 0; k < KEYS; k++) begin
         if (key_live[k]) begin
            if (found < 0 && key_word[k] == key)
               found = k;
         end else if (free_k < 0) begin
            free_k = k;
         end
      end
      if (found < 0) begin
         if (free_k < 0) begin
            o.status = iol_pkg::STATUS_FULL;
            outcomes.push_back(o);
            return;
         end
         found = free_k;
         key_live[found] = 1'b1;
         key_word[found] = key;
      end
      delta = delta / (millis ? 64'(iol_pkg::DIV_MS) : 64'(iol_pkg::DIV_US));
      slot = 0;
      while (delta > 1) begin
         delta = delta >> 1;
         slot++;
      end
      if (slot >= SLOTS)
         slot = SLOTS - 1;
      hist[found*SLOTS+slot] = hist[found*SLOTS+slot] + 1;
      o.status = iol_pkg::STATUS_COUNTED;
      o.key_index = found[3:0];
      o.bucket = slot[4:0];
      o.bucket_count = hist[found*SLOTS+slot];
      outcomes.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         cg_filter <= 0; disk_split <= 0; flag_split <= 0;
         queued <= 0; millis <= 0; dev_filter <= 0; target <= 0;
         for (int i = 0; i < TAGS; i++) tag_live[i] = 0;
         for (int i = 0; i < KEYS; i++) key_live[i] = 0;
         for (int i = 0; i < KEYS*SLOTS; i++) hist[i] = 0;
         outcomes.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (iol_pkg::csr_index_type'(csr_index))
               iol_pkg::CSR_FILTER_CGROUP: cg_filter <= csr_wdata[0];
               iol_pkg::CSR_PER_DISK:      disk_split <= csr_wdata[0];
               iol_pkg::CSR_PER_FLAGS:     flag_split <= csr_wdata[0];
               iol_pkg::CSR_QUEUED_MODE:   queued <= csr_wdata[0];
               iol_pkg::CSR_UNIT_MILLIS:   millis <= csr_wdata[0];
               iol_pkg::CSR_FILTER_DEVICE: dev_filter <= csr_wdata[0];
               iol_pkg::CSR_TARGET_DEVICE: target <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (outcomes.size() == 0) begin
               $error("unexpected rsp beat status=%0d", rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               e = outcomes.pop_front();
               if (rsp_status !== e.status || rsp_key_index !== e.key_index ||
                   rsp_bucket !== e.bucket || rsp_bucket_count !== e.bucket_count)
                  fail_count <= fail_count + 1;
               if (rsp_status !== e.status)
                  $error("status exp %0d got %0d", e.status, rsp_status);
               if (rsp_key_index !== e.key_index)
                  $error("key_index exp %0d got %0d", e.key_index, rsp_key_index);
               if (rsp_bucket !== e.bucket)
                  $error("bucket exp %0d got %0d", e.bucket, rsp_bucket);
               if (rsp_bucket_count !== e.bucket_count)
                  $error("bucket_count exp %0d got %0d", e.bucket_count, rsp_bucket_count);
            end
         end
         if (req_valid && req_ready)
            predict_latency();
      end
   end

endmodule

[dv/tb_io_latency_histogram_core.sv]
`timescale 1ns / 1ps
module tb_io_latency_histogram_core;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_func;
   logic [7:0]  req_request_tag;
   logic [63:0] req_timestamp_ns;
   logic        req_in_cgroup, req_has_elevator, req_disk_present;
   logic [11:0] req_disk_major;
   logic [19:0] req_disk_first_minor;
   logic [31:0] req_command_flags;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_key_index;
   logic [4:0]  rsp_bucket;
   logic [31:0] rsp_bucket_count;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count, pending_count;
   logic        calm, hold_rsp;
   logic [63:0] tag_time [256];
   logic [63:0] clock_ns;

   io_latency_histogram_core dut (.*);
   io_latency_histogram_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb_io_latency_histogram_core NOT OK");
      $finish;
   end

   initial begin
      int hold;
      rsp_ready = 0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            for (hold = 0; hold < 300; hold++) @(posedge clock);
            hold = 0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 22);
         @(posedge clock);
      end
   end

   task automatic csr_write(iol_pkg::csr_index_type idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic send_beat(iol_pkg::func_type f, logic [7:0] tag, logic [63:0] ts,
                            logic cg, logic elv, logic dp, logic [11:0] maj,
                            logic [19:0] mnr, logic [31:0] flags);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_request_tag <= tag;
      req_timestamp_ns <= ts;
      req_in_cgroup <= cg;
      req_has_elevator <= elv;
      req_disk_present <= dp;
      req_disk_major <= maj;
      req_disk_first_minor <= mnr;
      req_command_flags <= flags;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_beat();
      logic [7:0]  tag;
      logic [63:0] ts;
      logic [31:0] span;
      int          r;
      iol_pkg::func_type f;
      tag = 8'($urandom_range(15));
      if ($urandom_range(3) == 0) tag = 8'($urandom);
      r = $urandom_range(99);
      f = r < 40 ? iol_pkg::FUNC_INSERT : r < 55 ? iol_pkg::FUNC_ISSUE :
          r < 95 ? iol_pkg::FUNC_COMPLETE : iol_pkg::FUNC_UNUSED;
      clock_ns = clock_ns + 64'($urandom_range(5000));
      if (f == iol_pkg::FUNC_COMPLETE) begin
         span = $urandom >> $urandom_range(31);
         ts = tag_time[tag] + 64'({2'($urandom_range(3)), span, 10'($urandom_range(1023))});
         if ($urandom_range(15) == 0) ts = tag_time[tag] - 64'($urandom_range(100000));
         if ($urandom_range(31) == 0) ts = {$urandom, $urandom};
      end else begin
         ts = clock_ns;
         if ($urandom_range(31) == 0) ts = {$urandom, $urandom};
         tag_time[tag] = ts;
      end
      send_beat(f, tag, ts, $urandom_range(9) != 0, 1'($urandom), $urandom_range(5) != 0,
                12'($urandom_range(3)), 20'($urandom_range(2)),
                $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(3)));
   endtask

   initial begin
      int total;
      reset = 1; calm = 0; hold_rsp = 0;
      req_valid = 0; req_func = iol_pkg::FUNC_INSERT; req_request_tag = 0;
      req_timestamp_ns = 0;
      req_in_cgroup = 0; req_has_elevator = 0; req_disk_present = 0; req_disk_major = 0;
      req_disk_first_minor = 0; req_command_flags = 0;
      csr_we = 0; csr_index = iol_pkg::CSR_FILTER_CGROUP; csr_wdata = 0;
      clock_ns = 64'd1000;
      for (int i = 0; i < 256; i++) tag_time[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_beat(iol_pkg::FUNC_COMPLETE, 8'd5, 64'd100, 1, 0, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_INSERT, 8'd0, 64'd0, 1, 0, 1, 12'hFFF, 20'hFFFFF,
                32'hFFFFFFFF);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd0, 64'd0, 1, 0, 1, 12'hFFF, 20'hFFFFF,
                32'hFFFFFFFF);
      send_beat(iol_pkg::FUNC_INSERT, 8'd255, 64'd0, 1, 1, 1, 0, 0, 0);
      send_beat(iol_pkg::FUNC_INSERT, 8'd255, 64'd10, 1, 1, 1, 0, 0, 0);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd255, 64'hFFFFFFFFFFFFFFFF, 0, 1, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_ISSUE, 8'd1, 64'd5000, 1, 1, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd1, 64'd1000, 1, 1, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_UNUSED, 8'd2, 64'd1, 1, 1, 1, 1, 1, 1);
      send_beat(iol_pkg::FUNC_ISSUE, 8'd3, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd3, 64'h7FFFFFFFFFFFFFFE, 0, 0, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_INSERT, 8'd4, 64'd0, 0, 0, 0, 0, 0, 0);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd4, 64'd1999, 0, 0, 0, 0, 0, 0);
      idle_drain();

      csr_write(iol_pkg::CSR_FILTER_CGROUP, 1);
      csr_write(iol_pkg::CSR_PER_DISK, 1);
      csr_write(iol_pkg::CSR_PER_FLAGS, 1);
      csr_write(iol_pkg::CSR_QUEUED_MODE, 1);
      csr_write(iol_pkg::CSR_UNIT_MILLIS, 1);
      csr_write(iol_pkg::CSR_FILTER_DEVICE, 1);
      csr_write(iol_pkg::CSR_TARGET_DEVICE, 32'h00100001);
      send_beat(iol_pkg::FUNC_INSERT, 8'd6, 64'd0, 0, 0, 1, 1, 1, 0);
      send_beat(iol_pkg::FUNC_INSERT, 8'd7, 64'd0, 1, 0, 1, 1, 1, 0);
      send_beat(iol_pkg::FUNC_ISSUE, 8'd7, 64'd9, 1, 1, 1, 1, 1, 0);
      send_beat(iol_pkg::FUNC_INSERT, 8'd8, 64'd0, 1, 0, 1, 2, 1, 0);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd7, 64'd3000000, 1, 0, 1, 1, 1, 0);
      send_beat(iol_pkg::FUNC_COMPLETE, 8'd8, 64'd3000000, 1, 0, 1, 2, 1, 0);
      for (int i = 0; i < 18; i++) begin
         send_beat(iol_pkg::FUNC_INSERT, 8'(20 + i), 64'd0, 1, 0, 1, 1, 1, 0);
         send_beat(iol_pkg::FUNC_COMPLETE, 8'(20 + i), 64'd5000000, 1, 0, 1, 1, 1, 32'(i));
      end
      idle_drain();

      total = 0;
      for (int phase = 0; phase < 5; phase++) begin
         csr_write(iol_pkg::CSR_FILTER_CGROUP, $urandom_range(1));
         csr_write(iol_pkg::CSR_PER_DISK, $urandom_range(1));
         csr_write(iol_pkg::CSR_PER_FLAGS, phase == 4 ? 0 : $urandom_range(1));
         csr_write(iol_pkg::CSR_QUEUED_MODE, $urandom_range(1));
         csr_write(iol_pkg::CSR_UNIT_MILLIS, $urandom_range(1));
         csr_write(iol_pkg::CSR_FILTER_DEVICE, 32'($urandom_range(3) == 0));
         csr_write(iol_pkg::CSR_TARGET_DEVICE,
                   $urandom_range(1) ? 32'h00100001 : 32'hFFFFFFFF);
         calm = (phase == 2);
         for (int i = 0; i < 190; i++) begin
            if (phase == 1 && i == 20) hold_rsp <= 1;
            if (phase == 1 && i == 21) hold_rsp <= 0;
            random_beat();
            total++;
         end
         idle_drain();
      end

      if (fail_count == 0)
         $display("tb_io_latency_histogram_core OK");
      else
         $display("tb_io_latency_histogram_core NOT OK");
      $finish;
   end

endmodule
